FILE: rtl/dtl_pkg.sv
// ============================================================================
// dtl_pkg: types and constants of the dominator tree LCA unit
// Shared payload structs, sizes and the unit's default parameters.
// ============================================================================
package dtl_pkg;
    localparam int NODE_W   = 16;
    localparam int VALUE_W  = 17;
    localparam int DEF_MAX_NODES = 65536;
    localparam int DEF_LEVELS    = 16;

    localparam logic OP_PRED  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic KIND_ATTACH = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] other_node;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [NODE_W-1:0]  ancestor;
        logic [VALUE_W-1:0] value;
    } out_item_t;
endpackage

FILE: rtl/dtl_ram.sv
// ============================================================================
// dtl_ram: generic single-port synchronous RAM
// One access per cycle, read data registered; a write cycle reads the old word.
// ============================================================================
module dtl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: rtl/dag_dominator_tree_lca_unit.sv
// ============================================================================
// dag_dominator_tree_lca_unit: dominator tree with binary-lifting LCA
// Sequencer over a depth memory and an ancestor table memory.
// ============================================================================
// Every memory read is issued and then waited on. A query result is
// registered at the end of its LCA walk; an attach fills the new node's rows,
// after an LCA is folded first when the fold needs one.
// Throughput: one item at a time; the input stalls until the item is done and
// any result it yields is in the output register, which holds it while out_stall is high.
// Reset: clears control and fold state; root row and depth read as zero.
module dag_dominator_tree_lca_unit
    import dtl_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int LEVELS    = DEF_LEVELS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);
    localparam int NB = $clog2(MAX_NODES);
    localparam int LB = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int TB = NB + LB;
    localparam int GW = (LEVELS > NODE_W) ? LEVELS : NODE_W;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DEPU  = 12'b000000000010,
        S_DEPV  = 12'b000000000100,
        S_LIFT  = 12'b000000001000,
        S_CMPU  = 12'b000000010000,
        S_CMPV  = 12'b000000100000,
        S_FIN   = 12'b000001000000,
        S_DEPL  = 12'b000010000000,
        S_DONE  = 12'b000100000000,
        S_PDEP  = 12'b001000000000,
        S_FILL  = 12'b010000000000,
        S_EMIT  = 12'b100000000000
    } state_t;

    state_t            state_reg, state_next;
    logic              rd_wait_reg, rd_wait_next;
    in_item_t          item_reg, item_next;
    logic [NB-1:0]     u_reg, u_next, v_reg, v_next;
    logic [NODE_W-1:0] du_reg, du_next;
    logic [GW-1:0]     gap_reg, gap_next;
    logic [LB-1:0]     lvl_reg, lvl_next;
    logic [NODE_W-1:0] tu_reg, tu_next;
    logic [NB-1:0]     fold_reg, fold_next;
    logic              fold_act_reg, fold_act_next;
    logic [VALUE_W-1:0] sum_reg, sum_next;
    logic              ov_reg, ov_next;
    out_item_t         od_reg, od_next;

    logic              d_we, t_we;
    logic [NB-1:0]     d_addr;
    logic [TB-1:0]     t_addr;
    logic [NODE_W-1:0] d_wdata, t_wdata, d_rdata, t_rdata;
    logic [NODE_W-1:0] d_rd, t_rd;
    logic [NB-1:0]     d_lat_reg, t_lat_reg;

    dtl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_depth (
        .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
    );
    dtl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES * (1 << LB))) u_table (
        .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
    );

    // root row and depth read as zero without initialization
    always_ff @(posedge clk)
    begin
        d_lat_reg <= d_addr;
        t_lat_reg <= t_addr[TB-1 -: NB];
    end
    assign d_rd = (d_lat_reg == '0) ? '0 : d_rdata;
    assign t_rd = (t_lat_reg == '0) ? '0 : t_rdata;

    function automatic logic [TB-1:0] taddr(logic [NB-1:0] n, logic [LB-1:0] l);
        return {n, l};
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb
    begin
        logic [LB-1:0] top;
        logic [GW-1:0] step;
        logic [VALUE_W-1:0] s;
        top = LB'(LEVELS - 1);
        step = GW'(1) << top;
        state_next = state_reg; rd_wait_next = 1'b0; item_next = item_reg;
        u_next = u_reg; v_next = v_reg; du_next = du_reg;
        gap_next = gap_reg; lvl_next = lvl_reg; tu_next = tu_reg;
        fold_next = fold_reg; fold_act_next = fold_act_reg; sum_next = sum_reg;
        ov_next = ov_reg && out_stall; od_next = od_reg;
        d_we = 1'b0; t_we = 1'b0; d_addr = u_reg; t_addr = taddr(u_reg, lvl_reg);
        d_wdata = '0; t_wdata = '0; s = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    if (in_data.op == OP_QUERY)
                    begin
                        u_next = NB'(in_data.node); v_next = NB'(in_data.other_node);
                        state_next = S_DEPU; rd_wait_next = 1'b1;
                        d_addr = NB'(in_data.node);
                    end
                    else if (!fold_act_reg || fold_reg == '0)
                    begin
                        if (!fold_act_reg) fold_next = NB'(in_data.other_node);
                        fold_act_next = !in_data.last;
                        if (in_data.last)
                        begin
                            state_next = S_PDEP; rd_wait_next = 1'b1;
                            d_addr = fold_act_reg ? fold_reg : NB'(in_data.other_node);
                        end
                    end
                    else
                    begin
                        u_next = fold_reg; v_next = NB'(in_data.other_node);
                        state_next = S_DEPU; rd_wait_next = 1'b1;
                        d_addr = fold_reg;
                    end
                end
            end
            S_DEPU:
            begin
                d_addr = v_reg;
                if (rd_wait_reg) d_addr = u_reg;
                else
                begin
                    du_next = d_rd; state_next = S_DEPV; rd_wait_next = 1'b1;
                end
            end
            S_DEPV:
            begin
                d_addr = v_reg;
                if (!rd_wait_reg)
                begin
                    sum_next = VALUE_W'(du_reg) + VALUE_W'(d_rd);
                    if (du_reg < d_rd)
                    begin
                        u_next = v_reg; v_next = u_reg;
                        gap_next = GW'(d_rd - du_reg);
                    end
                    else gap_next = GW'(du_reg - d_rd);
                    lvl_next = top; state_next = S_LIFT;
                end
            end
            S_LIFT:
            begin
                if (gap_reg >= step || (lvl_reg < top && gap_reg[lvl_reg]))
                begin
                    t_addr = taddr(u_reg, (gap_reg >= step) ? top : lvl_reg);
                    rd_wait_next = 1'b1; state_next = S_DONE;
                    lvl_next = (gap_reg >= step) ? top : lvl_reg;
                end
                else if (lvl_reg != '0 && gap_reg != '0)
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
                else
                begin
                    lvl_next = top;
                    rd_wait_next = 1'b1;
                    if (u_reg == v_reg)
                    begin
                        state_next = S_DEPL; d_addr = u_reg;
                    end
                    else
                    begin
                        state_next = S_CMPU; t_addr = taddr(u_reg, top);
                    end
                end
            end
            S_DONE:
            begin
                // lift step result
                t_addr = taddr(u_reg, lvl_reg);
                if (!rd_wait_reg)
                begin
                    u_next = NB'(t_rd);
                    if (lvl_reg == top && gap_reg >= step) gap_next = gap_reg - step;
                    else
                    begin
                        gap_next = gap_reg & ~(GW'(1) << lvl_reg);
                        if (lvl_reg != '0) lvl_next = lvl_reg - 1'b1;
                    end
                    state_next = S_LIFT;
                end
            end
            S_CMPU:
            begin
                t_addr = taddr(u_reg, lvl_reg);
                if (!rd_wait_reg)
                begin
                    tu_next = t_rd; state_next = S_CMPV; rd_wait_next = 1'b1;
                    t_addr = taddr(v_reg, lvl_reg);
                end
            end
            S_CMPV:
            begin
                t_addr = taddr(v_reg, lvl_reg);
                if (!rd_wait_reg)
                begin
                    if (tu_reg != t_rd) begin u_next = NB'(tu_reg); v_next = NB'(t_rd); end
                    if (lvl_reg == '0)
                    begin
                        state_next = S_FIN; rd_wait_next = 1'b1;
                        t_addr = taddr((tu_reg != t_rd) ? NB'(tu_reg) : u_reg, '0);
                    end
                    else
                    begin
                        lvl_next = lvl_reg - 1'b1; state_next = S_CMPU; rd_wait_next = 1'b1;
                        t_addr = taddr((tu_reg != t_rd) ? NB'(tu_reg) : u_reg, lvl_reg - 1'b1);
                    end
                end
            end
            S_FIN:
            begin
                t_addr = taddr(u_reg, '0);
                if (!rd_wait_reg)
                begin
                    u_next = NB'(t_rd); state_next = S_DEPL; rd_wait_next = 1'b1;
                    d_addr = NB'(t_rd);
                end
            end
            S_DEPL:
            begin
                d_addr = u_reg;
                if (!rd_wait_reg)
                begin
                    if (item_reg.op == OP_PRED)
                    begin
                        fold_next = u_reg;
                        fold_act_next = !item_reg.last;
                        if (item_reg.last) begin state_next = S_PDEP; rd_wait_next = 1'b1; end
                        else state_next = S_IDLE;
                    end
                    else if (!ov_next)
                    begin
                        s = (sum_reg >= VALUE_W'(d_rd)) ? sum_reg - VALUE_W'(d_rd) : '0;
                        ov_next = 1'b1;
                        od_next = '{kind: KIND_QUERY, ancestor: NODE_W'(u_reg), value: s};
                        state_next = S_IDLE;
                    end
                end
            end
            S_PDEP:
            begin
                d_addr = fold_reg;
                if (!rd_wait_reg)
                begin
                    if (NB'(item_reg.node) == '0)
                    begin
                        du_next = '0; state_next = S_EMIT;
                    end
                    else
                    begin
                        du_next = (d_rd == '1) ? d_rd : d_rd + 1'b1;
                        d_we = 1'b1; d_addr = NB'(item_reg.node);
                        d_wdata = (d_rd == '1) ? d_rd : d_rd + 1'b1;
                        t_we = 1'b1; t_addr = taddr(NB'(item_reg.node), '0);
                        t_wdata = NODE_W'(fold_reg); tu_next = NODE_W'(fold_reg);
                        lvl_next = '0; state_next = (LEVELS > 1) ? S_FILL : S_EMIT;
                    end
                end
            end
            S_FILL:
            begin
                // read up(tu, lvl), write it as level lvl+1
                t_addr = taddr(NB'(tu_reg), lvl_reg);
                if (!rd_wait_reg) rd_wait_next = 1'b1;
                else
                begin
                    t_we = 1'b1; t_addr = taddr(NB'(item_reg.node), lvl_reg + 1'b1);
                    t_wdata = t_rd; tu_next = t_rd; lvl_next = lvl_reg + 1'b1;
                    if (32'(lvl_reg) + 2 >= LEVELS) state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ov_next)
                begin
                    ov_next = 1'b1;
                    od_next = '{kind: KIND_ATTACH,
                        ancestor: (NB'(item_reg.node) == '0) ? '0 : NODE_W'(fold_reg),
                        value: VALUE_W'(du_reg)};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; rd_wait_reg <= 1'b0; fold_act_reg <= 1'b0;
            fold_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; rd_wait_reg <= rd_wait_next;
            fold_act_reg <= fold_act_next; fold_reg <= fold_next; ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next; u_reg <= u_next; v_reg <= v_next;
        du_reg <= du_next; gap_reg <= gap_next;
        lvl_reg <= lvl_next; tu_reg <= tu_next; sum_reg <= sum_next;
        od_reg <= od_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_no_write_root: assert property (@(posedge clk) disable iff (!rst_n)
        d_we |-> d_addr != '0) else $error("root depth written");
endmodule
